// File: rtl/impact_pixel_hit_mapper_core_assert.svh
// Assertion macros for the pixel hit mapper.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef IMPACT_PIXEL_HIT_MAPPER_CORE_ASSERT_SVH
`define IMPACT_PIXEL_HIT_MAPPER_CORE_ASSERT_SVH
`ifndef SYNTH
`define IHM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IHM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define IHM_ASSERT(lbl, prop, msg)
`define IHM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/ihm_pkg.sv
// Shared types, codes and helpers of the pixel hit mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ihm_pkg;

    // Input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_IMPACT = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 2'd2;

    // Queue depths
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    typedef enum logic {
        OP_LOAD,
        OP_IMPACT
    } op_t;

    typedef struct packed {
        logic               cmd;
        logic [9:0]         pixel_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        pix_width;
        logic [30:0]        pix_height;
        logic [63:0]        time_stamp;
        logic [31:0]        energy_raw;
        logic [31:0]        photon_id;
        logic [31:0]        source_id;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [9:0]         hit_pixel;
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] det_x;
        logic signed [31:0] det_y;
        logic [63:0]        out_time;
        logic [31:0]        out_energy;
        logic [31:0]        out_photon;
        logic [31:0]        out_source;
        logic               last;
        logic               overflow;
    } result_t;

    // One classified beat from front to back: a table write or an impact.
    // For a load pos_x/pos_y hold the sign-extended centre, for an impact
    // the point in the detector frame at full precision.
    typedef struct packed {
        op_t                op;
        logic [9:0]         index;
        logic signed [32:0] pos_x;
        logic signed [32:0] pos_y;
        logic [30:0]        pix_w;
        logic [30:0]        pix_h;
        logic [10:0]        scan_len;
        logic [63:0]        time_stamp;
        logic [31:0]        energy;
        logic [31:0]        photon;
        logic [31:0]        source;
    } work_t;

    // Clamp a 34-bit signed value to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic [33:0] v);
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
        begin
            return v[31:0];
        end
        else if (v[33])
        begin
            return 32'h8000_0000;
        end
        else
        begin
            return 32'h7FFF_FFFF;
        end
    endfunction

endpackage

// File: rtl/ihm_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on ihm_pkg for nothing but the house import.
`timescale 1ns / 1ps

module ihm_fifo
    import ihm_pkg::*;
#(
    parameter type data_t = logic,
    parameter int  DEPTH  = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  data_t wr_data,
    input  logic  wr_en,
    output logic  full,
    output data_t rd_data,
    input  logic  rd_en,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    data_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/ihm_front.sv
// Front end: configuration registers, input acceptance and classification.
// Depends on ihm_pkg; feeds classified work beats to the middle queue.
`timescale 1ns / 1ps

module ihm_front
    import ihm_pkg::*;
#(
    parameter int NUM_PIXELS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data,
    input  item_t                item,
    input  logic                 push,
    output logic                 full,
    output work_t                work,
    output logic                 work_push,
    input  logic                 work_full
);

    logic signed [31:0] off_x_reg;
    logic signed [31:0] off_y_reg;
    logic [10:0]        pixel_count_reg;
    logic               accept;
    logic               index_ok;
    logic [10:0]        scan_len;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg       <= '0;
            off_y_reg       <= '0;
            pixel_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_DET_OFFSET_X: off_x_reg       <= cfg_data;
                CFG_DET_OFFSET_Y: off_y_reg       <= cfg_data;
                CFG_PIXEL_COUNT:  pixel_count_reg <= cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    assign full     = work_full;
    assign accept   = push && !full;
    assign index_ok = (32'(item.pixel_index) < 32'(NUM_PIXELS));
    assign scan_len = (32'(pixel_count_reg) > 32'(NUM_PIXELS)) ? 11'(NUM_PIXELS)
                                                              : pixel_count_reg;

    // Classify the beat: drop loads beyond the table, shift impacts
    always_comb
    begin
        work            = '0;
        work.index      = item.pixel_index;
        work.pix_w      = item.pix_width;
        work.pix_h      = item.pix_height;
        work.scan_len   = scan_len;
        work.time_stamp = item.time_stamp;
        work.energy     = item.energy_raw;
        work.photon     = item.photon_id;
        work.source     = item.source_id;
        if (item.cmd == CMD_LOAD)
        begin
            work.op    = OP_LOAD;
            work.pos_x = {item.pos_x[31], item.pos_x};
            work.pos_y = {item.pos_y[31], item.pos_y};
            work_push  = accept && index_ok;
        end
        else
        begin
            work.op    = OP_IMPACT;
            work.pos_x = {item.pos_x[31], item.pos_x} - {off_x_reg[31], off_x_reg};
            work.pos_y = {item.pos_y[31], item.pos_y} - {off_y_reg[31], off_y_reg};
            work_push  = accept;
        end
    end

endmodule

// File: rtl/ihm_back.sv
// Back end: pixel table memories, scan pipeline and hit collection.
// Depends on ihm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "impact_pixel_hit_mapper_core_assert.svh"

module ihm_back
    import ihm_pkg::*;
#(
    parameter int NUM_PIXELS = 1024,
    parameter int MAX_HITS   = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  work_t   work,
    input  logic    work_empty,
    output logic    work_pop,
    output result_t res,
    output logic    res_push,
    input  logic    res_full
);

    localparam int AW   = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int HC_W = $clog2(MAX_HITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [10:0]        cnt_reg;
    logic [10:0]        len_reg;

    logic signed [32:0] imp_dx_reg;
    logic signed [32:0] imp_dy_reg;
    logic [31:0]        det_x_reg;
    logic [31:0]        det_y_reg;
    logic [63:0]        time_reg;
    logic [31:0]        energy_reg;
    logic [31:0]        photon_reg;
    logic [31:0]        source_reg;

    logic [63:0]        centre_mem [NUM_PIXELS];
    logic [61:0]        size_mem   [NUM_PIXELS];

    logic               s1_vld_reg;
    logic [9:0]         s1_idx_reg;
    logic [63:0]        s1_centre_reg;
    logic [61:0]        s1_size_reg;

    logic               s2_vld_reg;
    logic [9:0]         s2_idx_reg;
    logic signed [33:0] s2_u_reg;
    logic signed [33:0] s2_v_reg;
    logic [30:0]        s2_w_reg;
    logic [30:0]        s2_h_reg;

    logic               s3_vld_reg;
    logic               s3_hit_reg;
    logic [9:0]         s3_idx_reg;
    logic [31:0]        s3_relx_reg;
    logic [31:0]        s3_rely_reg;

    logic               pend_vld_reg;
    logic [9:0]         pend_idx_reg;
    logic [31:0]        pend_relx_reg;
    logic [31:0]        pend_rely_reg;
    logic [HC_W-1:0]    hit_cnt_reg;
    logic               dropped_reg;

    logic               mem_we;
    logic               start;
    logic               take;
    logic               scan_push;
    logic               fin_push;
    logic               adv;
    logic               issue;
    logic               drained;
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic signed [33:0] u_next;
    logic signed [33:0] v_next;
    logic signed [34:0] two_u;
    logic signed [34:0] two_v;
    logic signed [34:0] wide_w;
    logic signed [34:0] wide_h;
    logic [35:0]        sum_x;
    logic [35:0]        sum_y;
    logic               in_x;
    logic               in_y;

    // Pop work beats only between impacts
    assign work_pop = (state_reg == ST_IDLE) && !work_empty;
    assign mem_we   = work_pop && (work.op == OP_LOAD);
    assign start    = work_pop && (work.op == OP_IMPACT);

    // Stall the scan only when a hit must leave and the result queue is full
    assign take      = s3_vld_reg && s3_hit_reg && (hit_cnt_reg < HC_W'(MAX_HITS));
    assign scan_push = take && pend_vld_reg;
    assign adv       = !(scan_push && res_full);
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < len_reg) && adv;
    assign drained   = (cnt_reg == len_reg) && !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;
    assign fin_push  = (state_reg == ST_DONE) && !res_full;
    assign res_push  = (scan_push && !res_full) || fin_push;

    // Offsets from the pixel centre
    assign cen_x  = s1_centre_reg[63:32];
    assign cen_y  = s1_centre_reg[31:0];
    assign u_next = {imp_dx_reg[32], imp_dx_reg} - {{2{cen_x[31]}}, cen_x};
    assign v_next = {imp_dy_reg[32], imp_dy_reg} - {{2{cen_y[31]}}, cen_y};

    // Closed-rectangle test: 2u <= w for u >= 0, 2u + w >= 0 for u < 0
    assign two_u  = {s2_u_reg, 1'b0};
    assign two_v  = {s2_v_reg, 1'b0};
    assign wide_w = {4'b0000, s2_w_reg};
    assign wide_h = {4'b0000, s2_h_reg};
    assign sum_x  = {s2_u_reg[33], s2_u_reg, 1'b0} + {5'b00000, s2_w_reg};
    assign sum_y  = {s2_v_reg[33], s2_v_reg, 1'b0} + {5'b00000, s2_h_reg};
    assign in_x   = s2_u_reg[33] ? !sum_x[35] : (two_u <= wide_w);
    assign in_y   = s2_v_reg[33] ? !sum_y[35] : (two_v <= wide_h);

    // Build the outgoing result: a held hit, the final hit or a miss
    always_comb
    begin
        res            = '0;
        res.det_x      = det_x_reg;
        res.det_y      = det_y_reg;
        res.out_time   = time_reg;
        res.out_energy = energy_reg;
        res.out_photon = photon_reg;
        res.out_source = source_reg;
        if (state_reg != ST_DONE)
        begin
            res.hit       = 1'b1;
            res.hit_pixel = pend_idx_reg;
            res.rel_x     = pend_relx_reg;
            res.rel_y     = pend_rely_reg;
        end
        else if (pend_vld_reg)
        begin
            res.hit       = 1'b1;
            res.hit_pixel = pend_idx_reg;
            res.rel_x     = pend_relx_reg;
            res.rel_y     = pend_rely_reg;
            res.last      = 1'b1;
            res.overflow  = dropped_reg;
        end
        else
        begin
            res.last = 1'b1;
        end
    end

    // Pixel table: write on load, read one entry per scan cycle unless the scan stalls
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            centre_mem[AW'(work.index)] <= {work.pos_x[31:0], work.pos_y[31:0]};
            size_mem[AW'(work.index)]   <= {work.pix_w, work.pix_h};
        end
        if (issue)
        begin
            s1_centre_reg <= centre_mem[AW'(cnt_reg)];
            s1_size_reg   <= size_mem[AW'(cnt_reg)];
        end
    end

    // Sequence the scan and collect hits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            len_reg      <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            hit_cnt_reg  <= '0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg    <= ST_SCAN;
                        cnt_reg      <= '0;
                        len_reg      <= work.scan_len;
                        pend_vld_reg <= 1'b0;
                        hit_cnt_reg  <= '0;
                        dropped_reg  <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (drained)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (issue)
            begin
                cnt_reg <= cnt_reg + 11'd1;
            end
            if (adv)
            begin
                s1_vld_reg <= issue;
                s2_vld_reg <= s1_vld_reg;
                s3_vld_reg <= s2_vld_reg;
                if (s3_vld_reg && s3_hit_reg)
                begin
                    if (take)
                    begin
                        pend_vld_reg <= 1'b1;
                        hit_cnt_reg  <= hit_cnt_reg + HC_W'(1);
                    end
                    else
                    begin
                        dropped_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Advance the datapath payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            imp_dx_reg <= work.pos_x;
            imp_dy_reg <= work.pos_y;
            det_x_reg  <= sat32({work.pos_x[32], work.pos_x});
            det_y_reg  <= sat32({work.pos_y[32], work.pos_y});
            time_reg   <= work.time_stamp;
            energy_reg <= work.energy;
            photon_reg <= work.photon;
            source_reg <= work.source;
        end
        if (issue)
        begin
            s1_idx_reg <= cnt_reg[9:0];
        end
        if (adv)
        begin
            s2_idx_reg  <= s1_idx_reg;
            s2_u_reg    <= u_next;
            s2_v_reg    <= v_next;
            s2_w_reg    <= s1_size_reg[61:31];
            s2_h_reg    <= s1_size_reg[30:0];
            s3_idx_reg  <= s2_idx_reg;
            s3_hit_reg  <= in_x && in_y;
            s3_relx_reg <= sat32(s2_u_reg);
            s3_rely_reg <= sat32(s2_v_reg);
            if (take)
            begin
                pend_idx_reg  <= s3_idx_reg;
                pend_relx_reg <= s3_relx_reg;
                pend_rely_reg <= s3_rely_reg;
            end
        end
    end

    `IHM_ASSERT(a_push_room, res_push |-> !res_full, "result beat pushed into a full queue")
    `IHM_ASSERT(a_scan_held, (res_push && state_reg == ST_SCAN) |-> pend_vld_reg, "scan pushed without a held hit")
    `IHM_ASSERT(a_drop_cap, dropped_reg |-> (hit_cnt_reg == HC_W'(MAX_HITS)), "hit dropped below the hit limit")
    `IHM_ASSERT(a_cnt_len, cnt_reg <= len_reg, "scan counter ran past the scan length")
    `IHM_ASSERT_NEXT(a_done_idle, state_reg == ST_DONE && !res_full, state_reg == ST_IDLE, "final beat sent but scan not closed")

endmodule

// File: rtl/impact_pixel_hit_mapper_core.sv
// Top level of the pixel hit mapper: front, middle queue, back, result queue.
// Depends on ihm_pkg, ihm_front, ihm_fifo and ihm_back.
//
// Use: input beats are pushed while full is low. A load beat (cmd low)
// writes one pixel entry of the table; a load whose index lies beyond the
// table is dropped. An impact beat (cmd high) is shifted by the detector
// offset and tested against table entries 0 .. min(pixel_count, NUM_PIXELS)-1.
// Results come out as a queue: read result while empty is low, pop to take
// it. Each impact gives one beat per hit pixel, lowest index first, at most
// MAX_HITS of them, or a single miss beat; last marks its final beat.
// A load is written to the table as it is popped. An impact holds the back
// end from its pop through one table read per entry scanned, the flush of
// the read and test pipeline, a drain check and the closing beat; the back
// end pops no new work beat before that closing beat has been sent.
// A two-entry queue lets the front take beats during a scan.
// A hit beat is held until the next hit or the end of the scan, so the first
// result of an impact is pushed once its second hit pixel is tested, or at
// the end of the scan for a miss or a single hit.
// Reset clears the configuration to zero and empties both queues; the pixel
// table holds nothing until loaded. When the receiver stalls, the four-entry
// result queue fills and the scan pauses until a beat is popped.
`timescale 1ns / 1ps

module impact_pixel_hit_mapper_core
    import ihm_pkg::*;
#(
    parameter int NUM_PIXELS = 1024,
    parameter int MAX_HITS   = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data,
    input  item_t                item,
    input  logic                 push,
    output logic                 full,
    output result_t              result,
    output logic                 empty,
    input  logic                 pop
);

    work_t   fe_work;
    logic    fe_push;
    logic    mid_full;
    work_t   mid_work;
    logic    mid_empty;
    logic    mid_pop;
    result_t be_res;
    logic    be_push;
    logic    out_full;

    ihm_front #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .item      (item),
        .push      (push),
        .full      (full),
        .work      (fe_work),
        .work_push (fe_push),
        .work_full (mid_full)
    );

    ihm_fifo #(
        .data_t (work_t),
        .DEPTH  (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (fe_work),
        .wr_en   (fe_push),
        .full    (mid_full),
        .rd_data (mid_work),
        .rd_en   (mid_pop),
        .empty   (mid_empty)
    );

    ihm_back #(
        .NUM_PIXELS (NUM_PIXELS),
        .MAX_HITS   (MAX_HITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (mid_work),
        .work_empty (mid_empty),
        .work_pop   (mid_pop),
        .res        (be_res),
        .res_push   (be_push),
        .res_full   (out_full)
    );

    ihm_fifo #(
        .data_t (result_t),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (be_res),
        .wr_en   (be_push),
        .full    (out_full),
        .rd_data (result),
        .rd_en   (pop),
        .empty   (empty)
    );

endmodule

// File: sim/ihm_hit_checker.sv
// Checker for the pixel hit mapper: mirrors the pixel table and registers,
// predicts the result beats of each accepted impact and compares them in order.
// Depends on ihm_pkg for the beat types, command codes and register indexes.
`timescale 1ns / 1ps

module ihm_hit_checker
    import ihm_pkg::*;
#(
    parameter int NUM_PIXELS = 1024,
    parameter int MAX_HITS   = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data,
    input  item_t                item,
    input  logic                 push,
    input  logic                 full,
    input  result_t              result,
    input  logic                 empty,
    input  logic                 pop,
    output int                   errors,
    output int                   beats_due
);

    localparam longint I32_MAX     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint I32_MIN     = -64'sh0000_0000_8000_0000;

    // Mirror of the pixel table and the registers
    logic signed [31:0] centre_x [NUM_PIXELS];
    logic signed [31:0] centre_y [NUM_PIXELS];
    logic [30:0]        size_w   [NUM_PIXELS];
    logic [30:0]        size_h   [NUM_PIXELS];
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [10:0]        scan_count;

    // Result beats still owed by the block, oldest first
    result_t            hit_beats [$];

    function automatic logic [31:0] clamp_i32(input longint v);
        if (v > I32_MAX)
        begin
            return I32_MAX[31:0];
        end
        if (v < I32_MIN)
        begin
            return I32_MIN[31:0];
        end
        return v[31:0];
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    // Apply a load to the table, or work out the beats of an impact
    task automatic predict_hits(input item_t it);
        longint  dx;
        longint  dy;
        longint  u;
        longint  v;
        int      scan;
        int      i;
        int      n;
        bit      dropped;
        result_t r;
        result_t found [$];

        if (it.cmd == CMD_LOAD)
        begin
            // Drop loads aimed past the end of the table
            if (int'(it.pixel_index) < NUM_PIXELS)
            begin
                centre_x[it.pixel_index] = it.pos_x;
                centre_y[it.pixel_index] = it.pos_y;
                size_w[it.pixel_index]   = it.pix_width;
                size_h[it.pixel_index]   = it.pix_height;
            end
            return;
        end

        // Detector frame at full precision; only the reported copy saturates
        dx = longint'($signed(it.pos_x)) - longint'(offset_x);
        dy = longint'($signed(it.pos_y)) - longint'(offset_y);
        scan = (int'(scan_count) > NUM_PIXELS) ? NUM_PIXELS : int'(scan_count);
        dropped = 1'b0;

        r = '0;
        r.det_x      = clamp_i32(dx);
        r.det_y      = clamp_i32(dy);
        r.out_time   = it.time_stamp;
        r.out_energy = it.energy_raw;
        r.out_photon = it.photon_id;
        r.out_source = it.source_id;

        for (i = 0; i < scan; i++)
        begin
            u = dx - longint'(centre_x[i]);
            v = dy - longint'(centre_y[i]);
            // Closed rectangle: 2|u| <= width and 2|v| <= height
            if (2 * (u < 0 ? -u : u) <= longint'(size_w[i]) &&
                2 * (v < 0 ? -v : v) <= longint'(size_h[i]))
            begin
                if (found.size() >= MAX_HITS)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    r.hit       = 1'b1;
                    r.hit_pixel = 10'(i);
                    r.rel_x     = clamp_i32(u);
                    r.rel_y     = clamp_i32(v);
                    found.push_back(r);
                end
            end
        end

        if (found.size() == 0)
        begin
            // Miss: a single closing beat with no pixel
            r.last = 1'b1;
            found.push_back(r);
        end
        else
        begin
            n = found.size() - 1;
            found[n].last     = 1'b1;
            found[n].overflow = dropped;
        end

        foreach (found[k])
        begin
            hit_beats.push_back(found[k]);
        end
    endtask

    // Compare one popped beat with the oldest one owed
    task automatic check_beat(input result_t got);
        result_t want;

        if (hit_beats.size() == 0)
        begin
            flag_mismatch("result beat with nothing owed", got.hit_pixel, '0);
            return;
        end
        want = hit_beats.pop_front();
        if (got.hit !== want.hit)
            flag_mismatch("hit", got.hit, want.hit);
        if (got.hit_pixel !== want.hit_pixel)
            flag_mismatch("hit_pixel", got.hit_pixel, want.hit_pixel);
        if (got.rel_x !== want.rel_x)
            flag_mismatch("rel_x", got.rel_x, want.rel_x);
        if (got.rel_y !== want.rel_y)
            flag_mismatch("rel_y", got.rel_y, want.rel_y);
        if (got.det_x !== want.det_x)
            flag_mismatch("det_x", got.det_x, want.det_x);
        if (got.det_y !== want.det_y)
            flag_mismatch("det_y", got.det_y, want.det_y);
        if (got.out_time !== want.out_time)
            flag_mismatch("out_time", got.out_time, want.out_time);
        if (got.out_energy !== want.out_energy)
            flag_mismatch("out_energy", got.out_energy, want.out_energy);
        if (got.out_photon !== want.out_photon)
            flag_mismatch("out_photon", got.out_photon, want.out_photon);
        if (got.out_source !== want.out_source)
            flag_mismatch("out_source", got.out_source, want.out_source);
        if (got.last !== want.last)
            flag_mismatch("last", got.last, want.last);
        if (got.overflow !== want.overflow)
            flag_mismatch("overflow", got.overflow, want.overflow);
    endtask

    // Watch the three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors     = 0;
            offset_x   = '0;
            offset_y   = '0;
            scan_count = '0;
            hit_beats.delete();
        end
        else
        begin
            // Track register writes
            if (cfg_wr)
            begin
                case (cfg_idx)
                    CFG_DET_OFFSET_X: offset_x = cfg_data;
                    CFG_DET_OFFSET_Y: offset_y = cfg_data;
                    CFG_PIXEL_COUNT:  scan_count = cfg_data[10:0];
                    default:          ;
                endcase
            end
            // Check the result beat taken at this edge
            if (pop && !empty)
            begin
                check_beat(result);
            end
            // Predict the beats of an accepted input beat
            if (push && !full)
            begin
                predict_hits(item);
            end
        end
        beats_due = hit_beats.size();
    end

endmodule

// File: sim/tb_impact_pixel_hit_mapper_core.sv
// Testbench top for the pixel hit mapper core: drives table loads, impacts and
// register writes through the queue-style ports, idles both sides, gives the verdict.
// Depends on ihm_pkg, impact_pixel_hit_mapper_core and ihm_hit_checker.
`timescale 1ns / 1ps

module tb_impact_pixel_hit_mapper_core;
    import ihm_pkg::*;

    localparam int NUM_PIXELS    = 1024;
    localparam int MAX_HITS      = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_BEATS   = 85;
    localparam int CLUSTER_SPAN  = 3000;
    localparam int MAX_COUNT     = 40;
    localparam logic signed [31:0] I32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN  = 32'sh8000_0000;
    localparam logic [30:0]        SIZE_MAX = 31'h7FFF_FFFF;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_data;
    item_t                item;
    logic                 push;
    logic                 full;
    result_t              result;
    logic                 empty;
    logic                 pop;
    int                   errors;
    int                   beats_due;

    // Idle and stall odds of the current phase, in percent
    int                   send_idle_pct;
    int                   pop_stall_pct;
    bit                   hold_req;

    // Stimulus-side copy of the table, used only to aim impacts
    bit                   loaded [NUM_PIXELS];
    int                   tab_cx [NUM_PIXELS];
    int                   tab_cy [NUM_PIXELS];
    int                   tab_w  [NUM_PIXELS];
    int                   tab_h  [NUM_PIXELS];
    int                   filled;
    int                   cur_off_x;
    int                   cur_off_y;
    int                   cur_count;

    always #4 clk = ~clk;

    impact_pixel_hit_mapper_core #(
        .NUM_PIXELS (NUM_PIXELS),
        .MAX_HITS   (MAX_HITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item),
        .push     (push),
        .full     (full),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

    ihm_hit_checker #(
        .NUM_PIXELS (NUM_PIXELS),
        .MAX_HITS   (MAX_HITS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .item      (item),
        .push      (push),
        .full      (full),
        .result    (result),
        .empty     (empty),
        .pop       (pop),
        .errors    (errors),
        .beats_due (beats_due)
    );

    // Run limit
    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: stall at random, or hold off for a long stretch on request
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                pop <= ($urandom_range(99) >= pop_stall_pct);
                @(negedge clk);
            end
        end
    end

    function automatic int fit_i32(input longint v);
        if (v > longint'(I32_MAX))
        begin
            return I32_MAX;
        end
        if (v < longint'(I32_MIN))
        begin
            return I32_MIN;
        end
        return int'(v);
    endfunction

    function automatic int pick_offset();
        case ($urandom_range(3))
            0, 1:    return int'($urandom_range(4000)) - 2000;
            2:       return int'($urandom());
            default: return $urandom_range(1) ? I32_MAX : I32_MIN;
        endcase
    endfunction

    // Offset from a pixel centre: on either edge, inside, or just outside
    function automatic longint edge_offset(input int size);
        longint half;

        half = longint'(size) / 2;
        case ($urandom_range(3))
            0:       return -half;
            1:       return half;
            2:       return longint'($urandom_range(32'(2 * half))) - half;
            default: return $urandom_range(1) ? half + 1 : -half - 1;
        endcase
    endfunction

    // Mostly small pixels in a cluster, some blankets, some anywhere
    task automatic pick_geometry(output int cx, output int cy, output int w, output int h);
        case ($urandom_range(9))
            0:
            begin
                cx = int'($urandom());
                cy = int'($urandom());
                w  = int'($urandom() & 32'h7FFF_FFFF);
                h  = int'($urandom() & 32'h7FFF_FFFF);
            end
            1:
            begin
                cx = int'($urandom_range(2 * CLUSTER_SPAN)) - CLUSTER_SPAN;
                cy = int'($urandom_range(2 * CLUSTER_SPAN)) - CLUSTER_SPAN;
                w  = int'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
                h  = int'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
            end
            default:
            begin
                cx = int'($urandom_range(2 * CLUSTER_SPAN)) - CLUSTER_SPAN;
                cy = int'($urandom_range(2 * CLUSTER_SPAN)) - CLUSTER_SPAN;
                w  = int'($urandom_range(2 * CLUSTER_SPAN));
                h  = int'($urandom_range(2 * CLUSTER_SPAN));
            end
        endcase
    endtask

    // Offer one input beat, idling first at random, and wait for acceptance
    task automatic send_beat(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic load_pixel(input int idx, input int cx, input int cy,
                              input int w, input int h);
        item_t it;

        it.cmd         = CMD_LOAD;
        it.pixel_index = 10'(idx);
        it.pos_x       = cx;
        it.pos_y       = cy;
        it.pix_width   = w[30:0];
        it.pix_height  = h[30:0];
        it.time_stamp  = {$urandom(), $urandom()};
        it.energy_raw  = $urandom();
        it.photon_id   = $urandom();
        it.source_id   = $urandom();
        tab_cx[idx] = cx;
        tab_cy[idx] = cy;
        tab_w[idx]  = int'(w[30:0]);
        tab_h[idx]  = int'(h[30:0]);
        loaded[idx] = 1'b1;
        while (filled < NUM_PIXELS && loaded[filled])
        begin
            filled++;
        end
        send_beat(it);
    endtask

    task automatic send_impact(input int px, input int py);
        item_t it;

        it.cmd         = CMD_IMPACT;
        it.pixel_index = 10'($urandom());
        it.pos_x       = px;
        it.pos_y       = py;
        it.pix_width   = 31'($urandom());
        it.pix_height  = 31'($urandom());
        it.time_stamp  = {$urandom(), $urandom()};
        it.energy_raw  = $urandom();
        it.photon_id   = $urandom();
        it.source_id   = $urandom();
        send_beat(it);
    endtask

    // Aim at a scanned pixel most of the time, else near the origin or anywhere
    task automatic random_impact();
        int     k;
        int     lim;
        longint px;
        longint py;

        lim = (cur_count > NUM_PIXELS) ? NUM_PIXELS : cur_count;
        if (lim != 0 && $urandom_range(3) != 0)
        begin
            k  = $urandom_range(lim - 1);
            px = longint'(cur_off_x) + tab_cx[k] + edge_offset(tab_w[k]);
            py = longint'(cur_off_y) + tab_cy[k] + edge_offset(tab_h[k]);
        end
        else if ($urandom_range(1))
        begin
            px = longint'(cur_off_x) + int'($urandom_range(8000)) - 4000;
            py = longint'(cur_off_y) + int'($urandom_range(8000)) - 4000;
        end
        else
        begin
            px = int'($urandom());
            py = int'($urandom());
        end
        send_impact(fit_i32(px), fit_i32(py));
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_DET_OFFSET_X: cur_off_x = value;
            CFG_DET_OFFSET_Y: cur_off_y = value;
            CFG_PIXEL_COUNT:  cur_count = value & 32'h7FF;
            default:          ;
        endcase
        @(negedge clk);
        cfg_wr <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering, drain every owed beat, let a trailing load finish
    task automatic settle();
        push <= 1'b0;
        @(negedge clk);
        while (beats_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int cx;
        int cy;
        int w;
        int h;
        int idx;
        int lim;
        int ph;

        rst_n         = 1'b0;
        cfg_wr        = 1'b0;
        cfg_idx       = CFG_DET_OFFSET_X;
        cfg_data      = '0;
        item          = '0;
        push          = 1'b0;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        filled        = 0;
        cur_off_x     = 0;
        cur_off_y     = 0;
        cur_count     = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty scan: nothing loaded, count zero
        set_reg(CFG_DET_OFFSET_X, 0);
        set_reg(CFG_DET_OFFSET_Y, 0);
        set_reg(CFG_PIXEL_COUNT, 0);
        send_impact(0, 0);

        // Zero-size pixel, nine stacked maximal pixels, one at the far corner
        load_pixel(0, 100, -100, 0, 0);
        for (idx = 1; idx < 10; idx++)
        begin
            load_pixel(idx, 0, 0, SIZE_MAX, SIZE_MAX);
        end
        load_pixel(10, I32_MAX, I32_MIN, SIZE_MAX, SIZE_MAX);
        settle();

        // Too many hits, exact edges, just outside, extreme point
        set_reg(CFG_PIXEL_COUNT, 10);
        send_impact(100, -100);
        send_impact(32'sd1073741823, -32'sd1073741823);
        send_impact(32'sd1073741824, 0);
        send_impact(I32_MAX, I32_MIN);
        settle();

        // Detector frame beyond 32 bits: hit and miss that saturation would blur
        set_reg(CFG_DET_OFFSET_X, I32_MIN);
        set_reg(CFG_DET_OFFSET_Y, I32_MAX);
        set_reg(CFG_PIXEL_COUNT, 11);
        send_impact(32'sd1073741822, -32'sd1073741824);
        send_impact(32'sd1073741823, -32'sd1073741824);
        send_impact(I32_MIN, I32_MAX);

        // Random phases, one per idling mode
        for (ph = 0; ph < 4; ph++)
        begin
            settle();
            set_reg(CFG_DET_OFFSET_X, pick_offset());
            set_reg(CFG_DET_OFFSET_Y, pick_offset());
            lim = (filled < MAX_COUNT) ? filled : MAX_COUNT;
            set_reg(CFG_PIXEL_COUNT, $urandom_range(lim, 1));
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 70;
                    pop_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct = 24;
                    pop_stall_pct = 24;
                end
            endcase
            // Back up the result side while the sender keeps going
            if (ph == 0)
            begin
                @(posedge clk);
                hold_req = 1'b1;
                @(negedge clk);
            end
            repeat (PHASE_BEATS)
            begin
                if ($urandom_range(99) < 30)
                begin
                    if (filled < NUM_PIXELS && $urandom_range(1))
                        idx = filled;
                    else
                        idx = $urandom_range(filled - 1);
                    pick_geometry(cx, cy, w, h);
                    load_pixel(idx, cx, cy, w, h);
                end
                else
                begin
                    random_impact();
                end
            end
        end

        // Scan every loaded entry, first from a zero offset, then from extreme ones
        settle();
        send_idle_pct = 24;
        pop_stall_pct = 24;
        set_reg(CFG_DET_OFFSET_X, 0);
        set_reg(CFG_DET_OFFSET_Y, 0);
        set_reg(CFG_PIXEL_COUNT, filled);
        repeat (3) random_impact();
        settle();
        set_reg(CFG_DET_OFFSET_X, I32_MAX);
        set_reg(CFG_DET_OFFSET_Y, I32_MIN);
        repeat (3) random_impact();
        settle();

        if (errors == 0 && beats_due == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
